FILE: rtl/olph_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// olph_pkg: shared types and constants for the ordered linear-probe hash table
// Slot layout, request and status codes, register map and slot arithmetic.
// ----------------------------------------------------------------------------
package olph_pkg;

    localparam int CAPACITY = 1024;
    localparam int ADDR_W   = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int CFG_W    = 11;
    localparam int KEY_W    = 32;
    localparam int VAL_W    = 32;

    localparam logic [1:0] MK_EMPTY = 2'd0;
    localparam logic [1:0] MK_FULL  = 2'd1;
    localparam logic [1:0] MK_TOMB  = 2'd2;

    localparam logic [1:0] REQ_INSERT = 2'd0;
    localparam logic [1:0] REQ_QUERY  = 2'd1;
    localparam logic [1:0] REQ_REMOVE = 2'd2;

    localparam logic [2:0] ST_OK      = 3'd0;
    localparam logic [2:0] ST_REBUILD = 3'd1;
    localparam logic [2:0] ST_DUP     = 3'd2;
    localparam logic [2:0] ST_FULL    = 3'd3;
    localparam logic [2:0] ST_MISSING = 3'd4;

    localparam logic REG_BUCKET_COUNT     = 1'b0;
    localparam logic REG_REBUILD_INTERVAL = 1'b1;

    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic [VAL_W-1:0] value;
        logic [1:0]       mark;
    } slot_t;

    typedef struct packed {
        logic              rd_en;
        logic [ADDR_W-1:0] rd_addr;
        logic              wr_en;
        logic [ADDR_W-1:0] wr_addr;
        slot_t             wr_data;
    } mem_req_t;

    typedef struct packed {
        logic [CNT_W-1:0] slots;
        logic [CNT_W-1:0] interval;
        logic             interval_load;
    } cfg_t;

    function automatic logic [ADDR_W-1:0] next_slot(input logic [ADDR_W-1:0] s,
                                                   input logic [CNT_W-1:0] nb);
        if (CNT_W'(s) + CNT_W'(1) >= nb)
            return '0;
        return s + ADDR_W'(1);
    endfunction

    function automatic logic [ADDR_W-1:0] prev_slot(input logic [ADDR_W-1:0] s,
                                                   input logic [CNT_W-1:0] nb);
        logic [CNT_W-1:0] last;
        last = nb - CNT_W'(1);
        if (s == '0)
            return last[ADDR_W-1:0];
        return s - ADDR_W'(1);
    endfunction

endpackage
`default_nettype wire

FILE: rtl/ordered_linear_probe_hash_table_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ordered_linear_probe_hash_table_core: hash table with ordered linear probing
// Insert, query and remove on 32-bit keys with tombstones and a rebuild flag.
// ----------------------------------------------------------------------------
// One transaction is handled at a time. After reset the block sweeps all 1024
// slots of the slot memory to mark every slot empty and takes no transaction
// until then. A request computes its key's home slot, then probes slot by
// slot: memory read, stored-key home slot multiply, compare. An insert then
// re-reads its slot and writes it; one that slides a run also scans for the
// free slot and moves each record up one slot, all through the slot memory.
// A table-full insert or an unused request code goes straight to the result.
// The result is held in an output register while the next request is taken;
// a result still waiting there stalls the one after it.
module ordered_linear_probe_hash_table_core (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [2:0]                  paddr,
    input  wire logic [31:0]                 pwdata,
    output logic [31:0]                      prdata,
    output logic                             pready,
    input  wire logic                        in_valid,
    output logic                             in_ready,
    input  wire logic [1:0]                  req_type,
    input  wire logic [olph_pkg::KEY_W-1:0]  key_in,
    input  wire logic [olph_pkg::VAL_W-1:0]  value_in,
    output logic                             out_valid,
    input  wire logic                        out_ready,
    output logic [2:0]                       status,
    output logic [olph_pkg::VAL_W-1:0]       value_out,
    output logic [olph_pkg::CNT_W-1:0]       probe_misses,
    output logic [olph_pkg::CNT_W-1:0]       record_count
);
    import olph_pkg::*;

    logic [CFG_W-1:0]  bucket_count_reg;
    logic [CFG_W-1:0]  interval_reg;
    logic              wr_en;
    logic [CFG_W-1:0]  wval;
    logic [CFG_W-1:0]  interval_clamped;
    cfg_t              cfg;
    mem_req_t          mem_req;
    slot_t             q;
    logic [KEY_W-1:0]  hash_key;
    logic [CNT_W-1:0]  hash_slots;
    logic [ADDR_W-1:0] hash_home;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign wval   = pwdata[CFG_W-1:0];
    assign interval_clamped = (wval == '0) ? CFG_W'(1) :
                              (wval > CFG_W'(1024)) ? CFG_W'(1024) : wval;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bucket_count_reg <= CFG_W'(1024);
            interval_reg     <= CFG_W'(256);
        end
        else if (wr_en)
        begin
            if (paddr[2] == REG_BUCKET_COUNT)
                bucket_count_reg <= wval;
            else
                interval_reg <= interval_clamped;
        end
    end

    assign prdata = (paddr[2] == REG_BUCKET_COUNT) ? 32'(bucket_count_reg) : 32'(interval_reg);

    // A slot count of zero acts as one; counts above the memory size are capped.
    assign cfg.slots = (bucket_count_reg == '0) ? CNT_W'(1) :
                       (CNT_W'(bucket_count_reg) > CNT_W'(CAPACITY)) ? CNT_W'(CAPACITY) :
                       CNT_W'(bucket_count_reg);
    assign cfg.interval      = CNT_W'(interval_clamped);
    assign cfg.interval_load = wr_en && (paddr[2] == REG_REBUILD_INTERVAL);

    olph_slot_ram u_ram (
        .clk (clk),
        .req (mem_req),
        .q   (q)
    );

    olph_hash u_hash (
        .clk   (clk),
        .key   (hash_key),
        .slots (hash_slots),
        .home  (hash_home)
    );

    olph_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .req_type     (req_type),
        .key_in       (key_in),
        .value_in     (value_in),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .status       (status),
        .value_out    (value_out),
        .probe_misses (probe_misses),
        .record_count (record_count),
        .mem_req      (mem_req),
        .q            (q),
        .hash_key     (hash_key),
        .hash_slots   (hash_slots),
        .hash_home    (hash_home)
    );

endmodule
`default_nettype wire

FILE: rtl/olph_slot_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// olph_slot_ram: slot memory
// One write port and one read port; read data is registered and holds until
// the next read.
// ----------------------------------------------------------------------------
module olph_slot_ram (
    input  wire logic              clk,
    input  wire olph_pkg::mem_req_t req,
    output olph_pkg::slot_t        q
);
    import olph_pkg::*;

    slot_t mem [CAPACITY];
    slot_t q_reg;

    always_ff @(posedge clk)
    begin
        if (req.wr_en)
            mem[req.wr_addr] <= req.wr_data;
        if (req.rd_en)
            q_reg <= mem[req.rd_addr];
    end

    assign q = q_reg;

endmodule
`default_nettype wire

FILE: rtl/olph_hash.sv
`default_nettype none
// ----------------------------------------------------------------------------
// olph_hash: home slot unit
// Registers (key * slots) >> 32, the home slot of a key.
// ----------------------------------------------------------------------------
module olph_hash (
    input  wire logic                          clk,
    input  wire logic [olph_pkg::KEY_W-1:0]    key,
    input  wire logic [olph_pkg::CNT_W-1:0]    slots,
    output logic      [olph_pkg::ADDR_W-1:0]   home
);
    import olph_pkg::*;

    logic [KEY_W+CNT_W-1:0] prod;
    logic [ADDR_W-1:0]      home_reg;

    assign prod = (KEY_W+CNT_W)'(key) * (KEY_W+CNT_W)'(slots);

    always_ff @(posedge clk)
    begin
        home_reg <= prod[KEY_W +: ADDR_W];
    end

    assign home = home_reg;

endmodule
`default_nettype wire

FILE: rtl/olph_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// olph_ctrl: request sequencer
// Walks the slot memory to probe, slides runs, writes records and holds the
// table counters and the result register.
// ----------------------------------------------------------------------------
module olph_ctrl (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire olph_pkg::cfg_t              cfg,
    input  wire logic                        in_valid,
    output logic                             in_ready,
    input  wire logic [1:0]                  req_type,
    input  wire logic [olph_pkg::KEY_W-1:0]  key_in,
    input  wire logic [olph_pkg::VAL_W-1:0]  value_in,
    output logic                             out_valid,
    input  wire logic                        out_ready,
    output logic [2:0]                       status,
    output logic [olph_pkg::VAL_W-1:0]       value_out,
    output logic [olph_pkg::CNT_W-1:0]       probe_misses,
    output logic [olph_pkg::CNT_W-1:0]       record_count,
    output olph_pkg::mem_req_t               mem_req,
    input  wire olph_pkg::slot_t             q,
    output logic [olph_pkg::KEY_W-1:0]       hash_key,
    output logic [olph_pkg::CNT_W-1:0]       hash_slots,
    input  wire logic [olph_pkg::ADDR_W-1:0] hash_home
);
    import olph_pkg::*;

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_HOME, S_START, S_RD, S_LAT, S_EVAL,
        S_SLOT_RD, S_SLOT_LAT, S_END_RD, S_END_LAT, S_SHIFT_RD, S_SHIFT_WR,
        S_PUT, S_DONE
    } state_t;

    state_t            state_reg;
    logic [1:0]        req_reg;
    logic [KEY_W-1:0]  key_reg;
    logic [VAL_W-1:0]  val_reg;
    logic [CNT_W-1:0]  nb_reg;
    logic [CNT_W-1:0]  head_reg;
    logic [ADDR_W-1:0] h_reg;
    logic [ADDR_W-1:0] s_reg;
    logic [CNT_W-1:0]  m_reg;
    logic              wrapped_reg;
    logic [ADDR_W-1:0] end_reg;
    logic [CNT_W-1:0]  steps_reg;
    logic [ADDR_W-1:0] i_reg;
    logic [ADDR_W-1:0] clr_reg;
    logic [CNT_W-1:0]  live_reg;
    logic [CNT_W-1:0]  whead_reg;
    logic [CNT_W-1:0]  cdown_reg;
    logic [2:0]        rs_status_reg;
    logic [VAL_W-1:0]  rs_value_reg;
    logic              out_valid_reg;
    logic [2:0]        status_reg;
    logic [VAL_W-1:0]  value_out_reg;
    logic [CNT_W-1:0]  misses_reg;
    logic [CNT_W-1:0]  count_reg;

    logic              ins;
    logic              is_full;
    logic              match;
    logic              stop_here;
    logic [ADDR_W-1:0] s_nx;
    logic              wrap_nx;
    logic [CNT_W-1:0]  m_nx;
    logic              stop_adv;
    logic [CNT_W-1:0]  cdown_dec;
    logic [2:0]        cdown_status;
    logic [ADDR_W-1:0] p_slot;
    logic [ADDR_W-1:0] end_nx;
    logic [CNT_W-1:0]  head_in;
    logic [ADDR_W-1:0] h_start;

    assign ins      = (req_reg == REQ_INSERT);
    assign is_full  = (q.mark == MK_FULL);
    assign match    = is_full && (q.key == key_reg);
    assign stop_here = match || (q.mark == MK_EMPTY) ||
                       (is_full && (ins ? (hash_home >= h_reg) : (hash_home > h_reg)));
    assign s_nx     = next_slot(s_reg, nb_reg);
    assign wrap_nx  = (CNT_W'(s_reg) + CNT_W'(1) >= nb_reg);
    assign m_nx     = m_reg + CNT_W'(1);
    assign stop_adv = (CNT_W'(s_nx) == head_reg) || (m_nx >= nb_reg);
    assign cdown_dec = (cdown_reg != '0) ? cdown_reg - CNT_W'(1) : cdown_reg;
    assign cdown_status = (cdown_dec == '0) ? ST_REBUILD : ST_OK;
    assign p_slot   = prev_slot(i_reg, nb_reg);
    assign end_nx   = next_slot(end_reg, nb_reg);
    assign head_in  = (whead_reg < cfg.slots) ? whead_reg : '0;
    assign h_start  = (CNT_W'(hash_home) > head_reg) ? hash_home : head_reg[ADDR_W-1:0];

    assign hash_key   = (state_reg == S_HOME) ? key_reg : q.key;
    assign hash_slots = nb_reg;

    always_comb
    begin
        mem_req = '0;
        unique case (state_reg)
            S_CLEAR:
            begin
                mem_req.wr_en   = 1'b1;
                mem_req.wr_addr = clr_reg;
                mem_req.wr_data = '{key: '0, value: '0, mark: MK_EMPTY};
            end
            S_RD, S_SLOT_RD:
            begin
                mem_req.rd_en   = 1'b1;
                mem_req.rd_addr = s_reg;
            end
            S_END_RD:
            begin
                mem_req.rd_en   = 1'b1;
                mem_req.rd_addr = end_reg;
            end
            S_SHIFT_RD:
            begin
                mem_req.rd_en   = 1'b1;
                mem_req.rd_addr = p_slot;
            end
            S_SHIFT_WR:
            begin
                mem_req.wr_en   = 1'b1;
                mem_req.wr_addr = i_reg;
                mem_req.wr_data = q;
            end
            S_EVAL:
            begin
                // A remove that finds its key turns the slot into a tombstone.
                if (req_reg == REQ_REMOVE && match)
                begin
                    mem_req.wr_en   = 1'b1;
                    mem_req.wr_addr = s_reg;
                    mem_req.wr_data = '{key: q.key, value: q.value, mark: MK_TOMB};
                end
            end
            S_PUT:
            begin
                mem_req.wr_en   = 1'b1;
                mem_req.wr_addr = s_reg;
                mem_req.wr_data = '{key: key_reg, value: val_reg, mark: MK_FULL};
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_reg       <= '0;
            live_reg      <= '0;
            whead_reg     <= '0;
            cdown_reg     <= CNT_W'(256);
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (out_valid_reg && out_ready && state_reg != S_DONE)
                out_valid_reg <= 1'b0;
            if (cfg.interval_load)
                cdown_reg <= cfg.interval;

            unique case (state_reg)
                S_CLEAR:
                begin
                    clr_reg <= clr_reg + ADDR_W'(1);
                    if (CNT_W'(clr_reg) == CNT_W'(CAPACITY - 1))
                        state_reg <= S_IDLE;
                end
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        req_reg       <= req_type;
                        key_reg       <= key_in;
                        val_reg       <= value_in;
                        nb_reg        <= cfg.slots;
                        head_reg      <= head_in;
                        m_reg         <= '0;
                        wrapped_reg   <= 1'b0;
                        rs_value_reg  <= '0;
                        rs_status_reg <= (req_type == REQ_INSERT && live_reg >= cfg.slots) ?
                                         ST_FULL : ST_MISSING;
                        if (req_type == REQ_INSERT && live_reg >= cfg.slots)
                            state_reg <= S_DONE;
                        else if (req_type != REQ_INSERT && req_type != REQ_QUERY &&
                                 req_type != REQ_REMOVE)
                            state_reg <= S_DONE;
                        else
                            state_reg <= S_HOME;
                    end
                end
                S_HOME:
                    state_reg <= S_START;
                S_START:
                begin
                    h_reg     <= hash_home;
                    s_reg     <= h_start;
                    state_reg <= S_RD;
                end
                S_RD:
                    state_reg <= S_LAT;
                S_LAT:
                    state_reg <= S_EVAL;
                S_EVAL:
                begin
                    if (stop_here)
                    begin
                        if (ins)
                        begin
                            if (match)
                            begin
                                rs_status_reg <= ST_DUP;
                                state_reg     <= S_DONE;
                            end
                            else
                                state_reg <= S_SLOT_RD;
                        end
                        else
                        begin
                            if (match)
                            begin
                                if (req_reg == REQ_QUERY)
                                begin
                                    rs_status_reg <= ST_OK;
                                    rs_value_reg  <= q.value;
                                end
                                else
                                begin
                                    rs_status_reg <= cdown_status;
                                    cdown_reg     <= cdown_dec;
                                    if (live_reg != '0)
                                        live_reg <= live_reg - CNT_W'(1);
                                end
                            end
                            state_reg <= S_DONE;
                        end
                    end
                    else
                    begin
                        s_reg       <= s_nx;
                        m_reg       <= m_nx;
                        wrapped_reg <= wrapped_reg | wrap_nx;
                        if (stop_adv)
                            state_reg <= ins ? S_SLOT_RD : S_DONE;
                        else
                            state_reg <= S_RD;
                    end
                end
                S_SLOT_RD:
                    state_reg <= S_SLOT_LAT;
                S_SLOT_LAT:
                begin
                    if (q.mark != MK_EMPTY)
                    begin
                        end_reg   <= next_slot(s_reg, nb_reg);
                        steps_reg <= CNT_W'(1);
                        state_reg <= S_END_RD;
                    end
                    else
                    begin
                        if (wrapped_reg && CNT_W'(s_reg) == head_reg)
                            head_reg <= head_reg + CNT_W'(1);
                        state_reg <= S_PUT;
                    end
                end
                S_END_RD:
                    state_reg <= S_END_LAT;
                S_END_LAT:
                begin
                    if (is_full && steps_reg < nb_reg)
                    begin
                        end_reg   <= end_nx;
                        steps_reg <= steps_reg + CNT_W'(1);
                        state_reg <= S_END_RD;
                    end
                    else
                    begin
                        if ((end_reg < s_reg || wrapped_reg) && CNT_W'(end_reg) >= head_reg)
                            head_reg <= head_reg + CNT_W'(1);
                        i_reg     <= end_reg;
                        state_reg <= (end_reg == s_reg) ? S_PUT : S_SHIFT_RD;
                    end
                end
                S_SHIFT_RD:
                    state_reg <= S_SHIFT_WR;
                S_SHIFT_WR:
                begin
                    // The entry below moves up one slot; stop once the gap reaches the run start.
                    i_reg     <= p_slot;
                    state_reg <= (p_slot == s_reg) ? S_PUT : S_SHIFT_RD;
                end
                S_PUT:
                begin
                    whead_reg     <= head_reg;
                    live_reg      <= live_reg + CNT_W'(1);
                    cdown_reg     <= cdown_dec;
                    rs_status_reg <= cdown_status;
                    state_reg     <= S_DONE;
                end
                S_DONE:
                begin
                    if (!out_valid_reg || out_ready)
                    begin
                        out_valid_reg <= 1'b1;
                        status_reg    <= rs_status_reg;
                        value_out_reg <= rs_value_reg;
                        misses_reg    <= m_reg;
                        count_reg     <= live_reg;
                        state_reg     <= S_IDLE;
                    end
                end
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

    assign in_ready     = (state_reg == S_IDLE);
    assign out_valid    = out_valid_reg;
    assign status       = status_reg;
    assign value_out    = value_out_reg;
    assign probe_misses = misses_reg;
    assign record_count = count_reg;

endmodule
`default_nettype wire

FILE: rtl/olph_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// olph_checker: port-level checks for the hash table core
// Watches the handshakes and result fields seen at the top level.
// ----------------------------------------------------------------------------
module olph_checker (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        pready,
    input  wire logic                        in_valid,
    input  wire logic                        in_ready,
    input  wire logic                        out_valid,
    input  wire logic                        out_ready,
    input  wire logic [2:0]                  status,
    input  wire logic [olph_pkg::VAL_W-1:0]  value_out,
    input  wire logic [olph_pkg::CNT_W-1:0]  record_count
);
    import olph_pkg::*;

    // The memory sweep after reset keeps the request side closed.
    a_clear_after_reset: assert property (@(posedge clk)
        $rose(rst_n) |-> !in_ready)
        else $error("request accepted during the post-reset sweep");

    // Requests are handled one at a time.
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("request side reopened right after a transaction");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> record_count <= CNT_W'(CAPACITY))
        else $error("record count above the table size");

    a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(status) && $stable(value_out))
        else $error("stalled result changed");

    a_pready: assert property (@(posedge clk) disable iff (!rst_n)
        pready)
        else $error("configuration port stalled");

endmodule

bind ordered_linear_probe_hash_table_core olph_checker u_olph_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .pready       (pready),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .status       (status),
    .value_out    (value_out),
    .record_count (record_count)
);
`default_nettype wire
